### rtl/core/drfc_pkg.sv
// shared types, constants and codes of the diagnostic request frame checker
package drfc_pkg;

    // default largest frame length in bytes; longer frames saturate the count
    localparam int MAX_FRAME_DEF = 4095;
    // frame length as carried between front and back, wide enough for MAX_FRAME up to 65535
    localparam int LEN_W         = 16;
    // entries in the frame queue between front and back
    localparam int QUEUE_DEPTH   = 2;

    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 40;
    localparam int PLEN_W        = 12;

    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ENFORCE_CHECKSUM    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEVELOPMENT_MODE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SID_SESSION_CONTROL = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SID_ECU_RESET       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SID_SECURITY_ACCESS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SID_READ_BY_ID      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SID_WRITE_BY_ID     = 3'd6;

    // reset values of the service id registers
    localparam logic [7:0] SID_SESSION_CONTROL_RST = 8'h10;
    localparam logic [7:0] SID_ECU_RESET_RST       = 8'h11;
    localparam logic [7:0] SID_SECURITY_ACCESS_RST = 8'h27;
    localparam logic [7:0] SID_READ_BY_ID_RST      = 8'h22;
    localparam logic [7:0] SID_WRITE_BY_ID_RST     = 8'h2E;

    localparam logic [7:0] VERSION_CODE = 8'h01;
    localparam logic [7:0] CUSTOM_FIRST = 8'hF0;
    localparam logic [7:0] DEBUG_ID     = 8'hFD;

    localparam logic [LEN_W-1:0] MIN_FRAME      = 16'd4;
    localparam logic [LEN_W-1:0] ID_MIN_FRAME   = 16'd5;
    localparam logic [LEN_W-1:0] LEN_FIELD_BIAS = 16'd3;

    typedef enum logic [2:0] {
        ST_OK               = 3'd0,
        ST_BAD_FORMAT       = 3'd1,
        ST_BAD_LENGTH       = 3'd2,
        ST_UNKNOWN_SERVICE  = 3'd3,
        ST_BAD_SUBFUNC      = 3'd4
    } status_t;

    typedef struct packed {
        logic       enforce_checksum;
        logic       development_mode;
        logic [7:0] sid_session_control;
        logic [7:0] sid_ecu_reset;
        logic [7:0] sid_security_access;
        logic [7:0] sid_read_by_id;
        logic [7:0] sid_write_by_id;
    } cfg_t;

    // everything the back end needs about one finished frame
    typedef struct packed {
        logic [LEN_W-1:0] frame_len;
        logic             overlong;
        logic [7:0]       version_byte;
        logic [7:0]       length_byte;
        logic [7:0]       service_byte;
        logic [7:0]       fourth_byte;
        logic [7:0]       checksum_byte;
        logic [7:0]       running_sum;
    } summary_t;

    typedef struct packed {
        status_t           status;
        logic [7:0]        service_code;
        logic [7:0]        subfunc;
        logic [PLEN_W-1:0] payload_length;
        logic              length_field_mismatch;
        logic              checksum_mismatch;
    } result_t;

endpackage

### rtl/core/drfc_front.sv
// front end: per-beat byte count, running sum and header capture
module drfc_front #(
    parameter int MAX_FRAME = drfc_pkg::MAX_FRAME_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                beat,       // byte accepted this cycle
    input  logic [7:0]          frame_byte,
    input  logic                frame_end,
    output logic                push,
    output drfc_pkg::summary_t  summary
);

    localparam int CW = $clog2(MAX_FRAME + 1);

    logic [CW-1:0] count_reg,    count_next;
    logic [7:0]    sum_reg,      sum_next;
    logic [7:0]    version_reg,  version_next;
    logic [7:0]    length_reg,   length_next;
    logic [7:0]    service_reg,  service_next;
    logic [7:0]    fourth_reg,   fourth_next;
    logic          overlong_reg, overlong_next;
    logic          at_max;

    assign at_max = (count_reg == CW'(MAX_FRAME));

    // state after this byte, before the end-of-frame clear
    always_comb
    begin
        count_next    = count_reg;
        overlong_next = overlong_reg;
        version_next  = version_reg;
        length_next   = length_reg;
        service_next  = service_reg;
        fourth_next   = fourth_reg;
        if (!at_max)
        begin
            count_next = count_reg + CW'(1);
            if (count_reg == CW'(0))
                version_next = frame_byte;
            if (count_reg == CW'(1))
                length_next = frame_byte;
            if (count_reg == CW'(2))
                service_next = frame_byte;
            if (count_reg == CW'(3))
                fourth_next = frame_byte;
        end
        else
        begin
            overlong_next = 1'b1;
        end
        sum_next = sum_reg + frame_byte;
    end

    assign push = beat && frame_end;

    always_comb
    begin
        summary.frame_len     = drfc_pkg::LEN_W'(count_next);
        summary.overlong      = overlong_next;
        summary.version_byte  = version_next;
        summary.length_byte   = length_next;
        summary.service_byte  = service_next;
        summary.fourth_byte   = fourth_next;
        summary.checksum_byte = frame_byte;
        summary.running_sum   = sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_reg      <= '0;
            version_reg  <= '0;
            length_reg   <= '0;
            service_reg  <= '0;
            fourth_reg   <= '0;
            overlong_reg <= 1'b0;
        end
        else if (beat)
        begin
            if (frame_end)
            begin
                count_reg    <= '0;
                sum_reg      <= '0;
                version_reg  <= '0;
                length_reg   <= '0;
                service_reg  <= '0;
                fourth_reg   <= '0;
                overlong_reg <= 1'b0;
            end
            else
            begin
                count_reg    <= count_next;
                sum_reg      <= sum_next;
                version_reg  <= version_next;
                length_reg   <= length_next;
                service_reg  <= service_next;
                fourth_reg   <= fourth_next;
                overlong_reg <= overlong_next;
            end
        end
    end

endmodule

### rtl/core/drfc_queue.sv
// short queue of finished frame summaries between front and back
module drfc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  drfc_pkg::summary_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output drfc_pkg::summary_t head_data
);

    localparam int DEPTH = drfc_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    drfc_pkg::summary_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] fill_reg,   fill_next;
    logic          do_push, do_pop;

    assign full       = (fill_reg == NW'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            fill_next = fill_reg + NW'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/core/drfc_back.sv
// back end: frame checks, service lookup and registered result
module drfc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  drfc_pkg::cfg_t     cfg,
    input  logic               head_valid,
    input  drfc_pkg::summary_t head_data,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output drfc_pkg::result_t  out_result
);

    logic                          out_valid_reg;
    drfc_pkg::result_t             result_reg, result_next;
    logic [drfc_pkg::LEN_W-1:0]    len;
    logic [drfc_pkg::LEN_W-1:0]    plen_full;
    logic [7:0]                    sid;
    logic [7:0]                    expected_sum;
    logic                          short_frame;
    logic                          lmis, cmis;
    logic                          is_sub_service, is_id_service;

    assign pop = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        len            = head_data.frame_len;
        sid            = head_data.service_byte;
        short_frame    = (len < drfc_pkg::MIN_FRAME);
        plen_full      = short_frame ? '0 : len - drfc_pkg::MIN_FRAME;
        expected_sum   = 8'h00 - head_data.running_sum;
        lmis           = ({8'h00, head_data.length_byte} != (len - drfc_pkg::LEN_FIELD_BIAS));
        cmis           = (head_data.checksum_byte != expected_sum);
        is_sub_service = (sid == cfg.sid_session_control) || (sid == cfg.sid_ecu_reset) ||
                         (sid == cfg.sid_security_access);
        is_id_service  = (sid == cfg.sid_read_by_id) || (sid == cfg.sid_write_by_id);

        result_next.service_code          = sid;
        result_next.subfunc               = 8'h00;
        result_next.payload_length        = plen_full[drfc_pkg::PLEN_W-1:0];
        result_next.length_field_mismatch = 1'b0;
        result_next.checksum_mismatch     = 1'b0;

        if (short_frame || head_data.overlong)
        begin
            result_next.status = drfc_pkg::ST_BAD_LENGTH;
        end
        else
        begin
            result_next.length_field_mismatch = lmis;
            result_next.checksum_mismatch     = cmis;
            if (head_data.version_byte != drfc_pkg::VERSION_CODE)
                result_next.status = drfc_pkg::ST_BAD_FORMAT;
            else if (cmis && cfg.enforce_checksum)
                result_next.status = drfc_pkg::ST_BAD_FORMAT;
            else if (is_sub_service)
            begin
                result_next.status  = drfc_pkg::ST_OK;
                result_next.subfunc = head_data.fourth_byte;
            end
            else if (is_id_service)
                result_next.status = (len >= drfc_pkg::ID_MIN_FRAME) ?
                                     drfc_pkg::ST_OK : drfc_pkg::ST_BAD_SUBFUNC;
            else if (sid == drfc_pkg::DEBUG_ID)
                result_next.status = cfg.development_mode ?
                                     drfc_pkg::ST_OK : drfc_pkg::ST_BAD_SUBFUNC;
            else if ((sid >= drfc_pkg::CUSTOM_FIRST) && cfg.development_mode)
                result_next.status = drfc_pkg::ST_OK;
            else
                result_next.status = drfc_pkg::ST_UNKNOWN_SERVICE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            result_reg <= result_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule

### rtl/core/diag_request_frame_checker_core.sv
// top level of the diagnostic request frame checker
// Checks diagnostic request frames that arrive one byte per beat on the slave
// stream, tlast marking the checksum byte, and returns one result beat per
// frame on the master stream. While the queue is not full a byte is taken
// every cycle: the front end updates its byte count, 8-bit running sum and
// header capture on each beat, so throughput is one byte per clock. When the
// last beat arrives the front end hands a frame summary to a two-entry queue;
// the back end classifies the head of that queue combinationally and holds
// the result in an output register, which follows the queue entry. s_tready
// drops only when the queue is full, which happens only when the master side
// stalls; bytes in the middle of a frame are still gated by it.
// Configuration goes through cfg_we/cfg_index/cfg_data and must be written
// while no frame is in flight. Frames longer than MAX_FRAME bytes keep being
// summed but report bad length.
module diag_request_frame_checker_core #(
    parameter int MAX_FRAME = drfc_pkg::MAX_FRAME_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // slave stream: raw frame bytes
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [drfc_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] frame_byte
    input  logic                                s_tlast,   // frame_end
    // master stream: one result beat per frame
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [2:0] status, [10:3] service_code, [18:11] subfunc,
    // [30:19] payload_length, [31] length_field_mismatch,
    // [32] checksum_mismatch, [39:33] zero
    output logic [drfc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [drfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [drfc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PACKED_W = $bits(drfc_pkg::result_t);

    drfc_pkg::cfg_t     cfg_reg;
    drfc_pkg::summary_t front_summary;
    drfc_pkg::summary_t head_data;
    drfc_pkg::result_t  result;
    logic               beat;
    logic               push;
    logic               queue_full;
    logic               head_valid;
    logic               pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enforce_checksum    <= 1'b0;
            cfg_reg.development_mode    <= 1'b0;
            cfg_reg.sid_session_control <= drfc_pkg::SID_SESSION_CONTROL_RST;
            cfg_reg.sid_ecu_reset       <= drfc_pkg::SID_ECU_RESET_RST;
            cfg_reg.sid_security_access <= drfc_pkg::SID_SECURITY_ACCESS_RST;
            cfg_reg.sid_read_by_id      <= drfc_pkg::SID_READ_BY_ID_RST;
            cfg_reg.sid_write_by_id     <= drfc_pkg::SID_WRITE_BY_ID_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                drfc_pkg::REG_ENFORCE_CHECKSUM:    cfg_reg.enforce_checksum    <= cfg_data[0];
                drfc_pkg::REG_DEVELOPMENT_MODE:    cfg_reg.development_mode    <= cfg_data[0];
                drfc_pkg::REG_SID_SESSION_CONTROL: cfg_reg.sid_session_control <= cfg_data;
                drfc_pkg::REG_SID_ECU_RESET:       cfg_reg.sid_ecu_reset       <= cfg_data;
                drfc_pkg::REG_SID_SECURITY_ACCESS: cfg_reg.sid_security_access <= cfg_data;
                drfc_pkg::REG_SID_READ_BY_ID:      cfg_reg.sid_read_by_id      <= cfg_data;
                drfc_pkg::REG_SID_WRITE_BY_ID:     cfg_reg.sid_write_by_id     <= cfg_data;
                default:                           ;   // unused index, write dropped
            endcase
        end
    end

    // accept a byte whenever a finished frame has room in the queue
    assign s_tready = !queue_full;
    assign beat     = s_tvalid && s_tready;

    drfc_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .frame_byte (s_tdata[7:0]),
        .frame_end  (s_tlast),
        .push       (push),
        .summary    (front_summary)
    );

    drfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (front_summary),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    drfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // pack the result, first field in the low bits
    always_comb
    begin
        m_tdata = '0;
        m_tdata[PACKED_W-1:0] = {result.checksum_mismatch,
                                 result.length_field_mismatch,
                                 result.payload_length,
                                 result.subfunc,
                                 result.service_code,
                                 result.status};
    end

endmodule

### rtl/core/drfc_checker.sv
// port-level checks of the frame checker, bound to the top level
module drfc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [drfc_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // status stays within its defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] == drfc_pkg::ST_OK ||
                      m_tdata[2:0] == drfc_pkg::ST_BAD_FORMAT ||
                      m_tdata[2:0] == drfc_pkg::ST_BAD_LENGTH ||
                      m_tdata[2:0] == drfc_pkg::ST_UNKNOWN_SERVICE ||
                      m_tdata[2:0] == drfc_pkg::ST_BAD_SUBFUNC))
        else $error("undefined status code");

    // bad length frames carry no mismatch flags
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == drfc_pkg::ST_BAD_LENGTH) |-> (m_tdata[32:31] == 2'b00))
        else $error("mismatch flag on a bad length frame");

    // a sub-function is reported only for accepted frames
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[18:11] != 8'h00) |-> (m_tdata[2:0] == drfc_pkg::ST_OK))
        else $error("sub-function on a rejected frame");

endmodule

bind diag_request_frame_checker_core drfc_checker u_drfc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
